FILE: sv/pvd_pkg.sv
// Package for the prefix-length varint decoder: mode codes, field widths
// and the small lead-byte decoding functions. No dependencies.
`default_nettype none

package pvd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned ValueW  = 64;
    localparam int unsigned CountW  = 4;
    localparam int unsigned SumW    = 32;
    localparam int unsigned OutDataW = 72;  // value and count, padded to whole bytes

    // Longest encoding: a lead byte of all ones and eight data bytes.
    localparam logic [CountW-1:0] MaxBytes  = 4'd9;
    // Length from which a value can exceed what a 32-bit mode can hold.
    localparam logic [CountW-1:0] ClipBytes = 4'd5;

    typedef enum logic [2:0] {
        MODE_U64     = 3'd0,
        MODE_S64     = 3'd1,
        MODE_U32     = 3'd2,
        MODE_S32     = 3'd3,
        MODE_DELTA16 = 3'd4,
        MODE_DELTA32 = 3'd5
    } mode_t;

    // Number of leading one bits of a lead byte, 0 to 8.
    function automatic logic [CountW-1:0] lead_ones(input logic [ByteW-1:0] b);
        logic [CountW-1:0] n;
        case (b) inside
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    // Mask for the data bits left in the lead byte after the length prefix.
    function automatic logic [ByteW-1:0] lead_mask(input logic [CountW-1:0] ones);
        logic [ByteW-1:0] m;
        case (ones)
            4'd0:    m = 8'h7f;
            4'd1:    m = 8'h3f;
            4'd2:    m = 8'h1f;
            4'd3:    m = 8'h0f;
            4'd4:    m = 8'h07;
            4'd5:    m = 8'h03;
            4'd6:    m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Zigzag mapping at 32 bits: even codes are non-negative, odd negative.
    function automatic logic [SumW-1:0] zigzag32(input logic [SumW-1:0] u);
        return {1'b0, u[SumW-1:1]} ^ {SumW{u[0]}};
    endfunction

    function automatic logic [ValueW-1:0] zigzag64(input logic [ValueW-1:0] u);
        return {1'b0, u[ValueW-1:1]} ^ {ValueW{u[0]}};
    endfunction

endpackage

`default_nettype wire

FILE: sv/prefix_varint_decoder_unit.sv
// Top level of the prefix-length varint decoder: byte stream in, one decoded
// value per completed encoding out. Depends on pvd_pkg.
`default_nettype none

// The decoder takes one byte of the encoded stream per clock cycle, with no
// gaps, for as long as the result side keeps up. The leading one bits of the
// first byte of a value give its length (one to nine bytes); the remaining
// lead-byte bits and the following bytes, most significant first, form the
// count. The byte that completes a value produces one result item in the next
// cycle on the master side; all other bytes produce nothing. The per-byte
// work (prefix decode, an 8-bit shift of the gathered bits, the zigzag
// mapping and one 32-bit add for the delta modes) sits between the state
// registers and a single output register. The output register is the only
// buffering: s_tready stays high while that register is empty or is being
// emptied in the same cycle, so a stall on m_tready reaches the input after
// one held result. The mode register is sampled on the byte that completes a
// value and should only be written while the block is idle. A start flag on
// the first byte of a value clears the running delta sum before that value is
// added.
module prefix_varint_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Mode register write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,     // decode_mode
    // Encoded byte stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] data_byte
    input  wire logic        s_tuser,      // [0] start_vector
    // Decoded values.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,      // [63:0] value_bits, [67:64] byte_count, rest 0
    output logic             m_tuser       // [0] clipped
);

    // Decoder state.
    logic [2:0]                     decode_mode_reg;
    logic [pvd_pkg::ByteW-1:0]      lead_byte_reg;
    logic [pvd_pkg::ValueW-1:0]     gathered_reg;
    logic [pvd_pkg::CountW-1:0]     bytes_seen_reg;
    logic [pvd_pkg::SumW-1:0]       delta_sum_reg;

    // Output register.
    logic                           out_valid_reg;
    logic [pvd_pkg::ValueW-1:0]     out_value_reg;
    logic [pvd_pkg::CountW-1:0]     out_count_reg;
    logic                           out_clip_reg;

    logic                           in_accept;
    logic                           first_byte;
    logic [pvd_pkg::ByteW-1:0]      lead;
    logic [pvd_pkg::CountW-1:0]     ones;
    logic [pvd_pkg::CountW-1:0]     total;
    logic [pvd_pkg::ValueW-1:0]     gathered_next;
    logic [pvd_pkg::CountW-1:0]     seen_inc;
    logic                           done;
    logic [pvd_pkg::SumW-1:0]       sum_base;
    logic [pvd_pkg::SumW-1:0]       c32;
    logic                           clip32;
    logic [pvd_pkg::SumW-1:0]       zz32;
    logic [pvd_pkg::SumW-1:0]       sum_added;
    logic [pvd_pkg::SumW-1:0]       delta_sum_next;
    logic [pvd_pkg::ValueW-1:0]     value_next;
    logic                           clip_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // Prefix decode uses the incoming byte when it opens a value.
    assign first_byte = (bytes_seen_reg == '0);
    assign lead       = first_byte ? s_tdata : lead_byte_reg;
    assign ones       = pvd_pkg::lead_ones(lead);
    assign total      = (ones == 4'd8) ? pvd_pkg::MaxBytes : ones + 4'd1;

    assign gathered_next = first_byte
        ? {{(pvd_pkg::ValueW-pvd_pkg::ByteW){1'b0}}, s_tdata & pvd_pkg::lead_mask(ones)}
        : {gathered_reg[pvd_pkg::ValueW-pvd_pkg::ByteW-1:0], s_tdata};
    assign seen_inc = bytes_seen_reg + 4'd1;
    assign done     = (seen_inc == total);

    // A start flag on a first byte clears the running sum before any add.
    assign sum_base = (first_byte && s_tuser) ? '0 : delta_sum_reg;

    // 32-bit view of the count: five-byte values are cut to 32 bits, longer
    // values are taken as zero.
    always_comb
    begin
        if (total < pvd_pkg::ClipBytes)
        begin
            c32    = gathered_next[pvd_pkg::SumW-1:0];
            clip32 = 1'b0;
        end
        else if (total == pvd_pkg::ClipBytes)
        begin
            c32    = gathered_next[pvd_pkg::SumW-1:0];
            clip32 = (lead[2:0] != 3'b000);
        end
        else
        begin
            c32    = '0;
            clip32 = 1'b1;
        end
    end

    assign zz32      = pvd_pkg::zigzag32(c32);
    assign sum_added = sum_base + zz32;

    always_comb
    begin
        delta_sum_next = sum_base;
        case (decode_mode_reg)
            pvd_pkg::MODE_S64:
            begin
                value_next = pvd_pkg::zigzag64(gathered_next);
                clip_next  = 1'b0;
            end
            pvd_pkg::MODE_U32:
            begin
                value_next = {32'd0, c32};
                clip_next  = clip32;
            end
            pvd_pkg::MODE_S32:
            begin
                value_next = {{32{zz32[pvd_pkg::SumW-1]}}, zz32};
                clip_next  = clip32;
            end
            pvd_pkg::MODE_DELTA16:
            begin
                if (done)
                    delta_sum_next = sum_added;
                value_next = {48'd0, sum_added[15:0]};
                clip_next  = clip32;
            end
            pvd_pkg::MODE_DELTA32:
            begin
                if (done)
                    delta_sum_next = sum_added;
                value_next = {32'd0, sum_added};
                clip_next  = clip32;
            end
            default:
            begin
                // Unsigned 64-bit; the two unused codes land here as well.
                value_next = gathered_next;
                clip_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= pvd_pkg::MODE_U64;
            lead_byte_reg   <= '0;
            gathered_reg    <= '0;
            bytes_seen_reg  <= '0;
            delta_sum_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                decode_mode_reg <= cfg_data;

            if (in_accept)
            begin
                lead_byte_reg  <= lead;
                gathered_reg   <= gathered_next;
                bytes_seen_reg <= done ? '0 : seen_inc;
                delta_sum_reg  <= delta_sum_next;
            end

            if (in_accept && done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (in_accept && done)
        begin
            out_value_reg <= value_next;
            out_count_reg <= total;
            out_clip_reg  <= clip_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pvd_pkg::OutDataW-pvd_pkg::ValueW-pvd_pkg::CountW){1'b0}},
                       out_count_reg, out_value_reg};
    assign m_tuser  = out_clip_reg;

endmodule

`default_nettype wire

FILE: sv/pvd_checker.sv
// Port-level checker for the prefix-length varint decoder and its bind to
// the top level. Depends on prefix_varint_decoder_unit.
`default_nettype none

module pvd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser
);

    // A held result is not changed or dropped.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Input is taken exactly when the output register can make room.
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stage");

    // A value takes one to nine bytes and the padding stays clear.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd9
                     && m_tdata[71:68] == 4'd0)
        else $error("byte count out of range");

    // Clipping only happens for values of five bytes or more.
    a_clip_long: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[67:64] >= 4'd5)
        else $error("clip flag on a short value");

endmodule

bind prefix_varint_decoder_unit pvd_checker u_pvd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
